// ===== sv/efds_pkg.sv =====
`timescale 1ns / 1ps
package efds_pkg;

    localparam int DefNumSlots = 64;
    localparam int TickW       = 31;
    localparam int IdW         = 16;
    localparam int SlotW       = 6;
    localparam int TimeW       = 32;
    localparam int WideW       = 33;

    // Input packing: slot, flags, budget, done, deadline, period, start, id, now.
    localparam int InDataW  = 216;
    localparam int OutDataW = 56;

    typedef enum logic [1:0] {
        OUT_NONE       = 2'd0,
        OUT_MISSED     = 2'd1,
        OUT_FEASIBLE   = 2'd2,
        OUT_INFEASIBLE = 2'd3
    } t_outcome;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLIP,
        ST_LOAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic            run;
        logic            rt;
        logic            wait_f;
        logic [TickW-1:0] budget;
        logic [TickW-1:0] done;
        logic [TickW-1:0] deadline;
        logic [TickW-1:0] period;
        logic [TickW-1:0] start;
        logic [IdW-1:0]   id;
    } t_slot;

endpackage

// ===== sv/earliest_feasible_deadline_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata low bit first)
// s_axis    in   tdata: slot, runnable, rt_task, waiting, exec_budget, exec_done,
//                deadline, period_len, period_start, task_id, now; tuser: kind
// m_axis    out  tdata: chosen_slot, chosen_id, granted_ticks; tuser: outcome
//
// A write updates its slot at the accepting edge. A schedule request reads the
// slot table once to select a winner and, for a feasible winner only, once more
// to clip its time, set by the single read port of the slot memory; the result
// is then registered. Reset is synchronous and clears the flag bits of all
// slots; other slot fields are valid only once written.
// A result waits in the output register; the next item is taken meanwhile.
module earliest_feasible_deadline_scheduler_unit #(
    parameter int NUM_SLOTS = efds_pkg::DefNumSlots
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // slot, runnable, rt_task, waiting, exec_budget, exec_done, deadline,
    // period_len, period_start, task_id, now
    input  logic [efds_pkg::InDataW-1:0]  s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // chosen_slot, chosen_id, granted_ticks
    output logic [efds_pkg::OutDataW-1:0] m_axis_tdata,
    // outcome
    output logic [1:0]                    m_axis_tuser
);
    import efds_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    t_slot            mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_run, r_rt, r_wait;
    t_slot            r_rd;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rvalid, n_rvalid;
    logic [AW-1:0]    r_ridx, n_ridx;
    logic [TickW-1:0] r_now;

    logic             r_mis_v, r_fea_v, r_inf_v;
    logic [AW-1:0]    r_mis_s, r_fea_s, r_inf_s;
    logic [IdW-1:0]   r_mis_id, r_fea_id, r_inf_id;
    logic [TickW-1:0] r_fea_dl;
    logic signed [WideW:0] r_rem, r_alloc;

    logic             r_ov;
    t_outcome         r_oc;
    logic [SlotW-1:0] r_oslot;
    logic [IdW-1:0]   r_oid;
    logic [TimeW-1:0] r_otime;

    // Input field slices.
    logic [SlotW-1:0] in_slot;
    t_slot            in_rec;
    logic [TickW-1:0] in_now;
    assign in_slot = s_axis_tdata[SlotW-1:0];
    assign in_rec.run      = s_axis_tdata[6];
    assign in_rec.rt       = s_axis_tdata[7];
    assign in_rec.wait_f   = s_axis_tdata[8];
    assign in_rec.budget   = s_axis_tdata[39:9];
    assign in_rec.done     = s_axis_tdata[70:40];
    assign in_rec.deadline = s_axis_tdata[101:71];
    assign in_rec.period   = s_axis_tdata[132:102];
    assign in_rec.start    = s_axis_tdata[163:133];
    assign in_rec.id       = s_axis_tdata[179:164];
    assign in_now          = s_axis_tdata[210:180];

    logic acc, do_write, slot_ok;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign do_write = acc && (s_axis_tuser == KIND_WRITE);
    assign slot_ok  = (int'(in_slot) < NUM_SLOTS);

    logic [AW-1:0] wr_a;
    assign wr_a = AW'(in_slot);

    always_ff @(posedge i_clk) begin
        if (do_write && slot_ok) begin
            mem[wr_a] <= in_rec;
        end
        r_rd <= mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0; r_rt <= '0; r_wait <= '0;
        end else if (do_write && slot_ok) begin
            r_run[wr_a]  <= in_rec.run;
            r_rt[wr_a]   <= in_rec.rt;
            r_wait[wr_a] <= in_rec.wait_f;
        end
    end

    // Arithmetic on the slot just read.
    logic signed [WideW:0] rem, dl_now, lax, now_rem, wake_end, wd, dd;
    logic compete, miss, sleeper;
    assign rem     = $signed({3'b0, r_rd.budget}) - $signed({3'b0, r_rd.done});
    assign dl_now  = $signed({3'b0, r_rd.deadline}) - $signed({3'b0, r_now});
    assign lax     = dl_now - rem;
    assign compete = r_run[r_ridx] && r_rt[r_ridx];
    assign miss    = (r_now >= r_rd.deadline) && (rem > 0);
    assign now_rem = $signed({3'b0, r_now}) + r_rem;
    assign wake_end = $signed({3'b0, r_rd.start}) + $signed({3'b0, r_rd.period});
    assign wd      = $signed({3'b0, r_rd.start}) - $signed({3'b0, r_now});
    assign dd      = $signed({3'b0, r_fea_dl}) - $signed({3'b0, r_now});
    assign sleeper = r_rt[r_ridx] && r_wait[r_ridx]
                  && ($signed({3'b0, r_rd.start}) < now_rem)
                  && (wake_end <= $signed({3'b0, r_fea_dl}))
                  && !(wake_end == $signed({3'b0, r_fea_dl}) && r_rd.id > r_fea_id);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_rvalid = 1'b0;
        n_ridx   = r_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (acc && s_axis_tuser == KIND_SCHED) n_state = ST_SCAN;
            end
            ST_SCAN, ST_CLIP: begin
                if (r_idx < CW'(NUM_SLOTS)) begin
                    n_rvalid = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else if (!r_rvalid) begin
                    n_idx   = '0;
                    n_state = (r_state == ST_SCAN) ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD: begin
                // Form the starting allocation; a feasible winner goes on to the clipping pass.
                if (!r_mis_v && r_fea_v) n_state = ST_CLIP;
                else n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!(r_ov && !m_axis_tready)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_rvalid <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rvalid <= n_rvalid;
            if (r_state == ST_OUT && !(r_ov && !m_axis_tready)) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= n_ridx;
        if (acc && s_axis_tuser == KIND_SCHED) begin
            r_now   <= in_now;
            r_mis_v <= 1'b0; r_fea_v <= 1'b0; r_inf_v <= 1'b0;
        end
        if (r_state == ST_SCAN && r_rvalid && compete) begin
            if (miss) begin
                if (!r_mis_v || r_rd.id < r_mis_id) begin
                    r_mis_v <= 1'b1; r_mis_s <= r_ridx; r_mis_id <= r_rd.id;
                end
            end else if (lax >= 0) begin
                if (!r_fea_v || r_rd.deadline < r_fea_dl
                    || (r_rd.deadline == r_fea_dl && r_rd.id < r_fea_id)) begin
                    r_fea_v <= 1'b1; r_fea_s <= r_ridx; r_fea_id <= r_rd.id;
                    r_fea_dl <= r_rd.deadline; r_rem <= rem;
                end
            end else if (!r_inf_v || r_rd.id < r_inf_id) begin
                r_inf_v <= 1'b1; r_inf_s <= r_ridx; r_inf_id <= r_rd.id;
            end
        end
        if (r_state == ST_LOAD) r_alloc <= (r_rem < dd) ? r_rem : dd;
        if (r_state == ST_CLIP && r_rvalid && sleeper && r_alloc > wd) r_alloc <= wd;
        if (r_state == ST_OUT && !(r_ov && !m_axis_tready)) begin
            if (r_mis_v) begin
                r_oc <= OUT_MISSED; r_oslot <= SlotW'(r_mis_s);
                r_oid <= r_mis_id; r_otime <= '0;
            end else if (r_fea_v) begin
                r_oc <= OUT_FEASIBLE; r_oslot <= SlotW'(r_fea_s);
                r_oid <= r_fea_id; r_otime <= r_alloc[TimeW-1:0];
            end else if (r_inf_v) begin
                r_oc <= OUT_INFEASIBLE; r_oslot <= SlotW'(r_inf_s);
                r_oid <= r_inf_id; r_otime <= '0;
            end else begin
                r_oc <= OUT_NONE; r_oslot <= '0; r_oid <= '0; r_otime <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_oc;
    assign m_axis_tdata  = {2'b0, r_otime, r_oid, r_oslot};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while a decision is in progress");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_otime) && $stable(r_oc)))
        else $error("stalled result changed");
    a_clip_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLIP) |-> (r_fea_v && !r_mis_v))
        else $error("clipping pass without a feasible winner");

endmodule

// ===== tb/tb_earliest_feasible_deadline_scheduler_unit.sv =====
`timescale 1ns / 1ps
module tb_earliest_feasible_deadline_scheduler_unit;
    import efds_pkg::*;

    localparam int NSlots = DefNumSlots;
    localparam int NumRandom = 430;
    localparam int IdleTail = 200;

    typedef struct packed {
        logic [5:0]  slot;
        logic        run;
        logic        rt;
        logic        wait_f;
        logic [30:0] budget;
        logic [30:0] done;
        logic [30:0] deadline;
        logic [30:0] period;
        logic [30:0] start;
        logic [15:0] id;
        logic [30:0] now;
    } t_item;

    localparam int ItemW = $bits(t_item);

    typedef struct packed {
        t_outcome    outcome;
        logic [5:0]  slot;
        logic [15:0] id;
        logic [31:0] alloc;
    } t_decision;

    typedef struct {
        logic      kind;
        t_item     item;
        logic      has_fixed;
        t_decision fixed;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    // Predictor copy of the slot table.
    t_slot     table_q [NSlots];
    t_decision decisions_due [$];
    int        fail_count = 0;
    bit        quiet_tail = 1'b0;
    bit        hold_off = 1'b0;
    t_row      rows [$];

    earliest_feasible_deadline_scheduler_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_decision decide(input logic [30:0] now);
        t_decision d;
        int missed, feas, infeas;
        longint rem, lax, alloc, wake_end, wd, frem;
        missed = -1; feas = -1; infeas = -1;
        d = '{OUT_NONE, 6'd0, 16'd0, 32'd0};
        for (int i = 0; i < NSlots; i++) begin
            if (!(table_q[i].run && table_q[i].rt)) continue;
            rem = longint'(table_q[i].budget) - longint'(table_q[i].done);
            if (now >= table_q[i].deadline && rem > 0) begin
                if (missed < 0 || table_q[i].id < table_q[missed].id) missed = i;
                continue;
            end
            lax = (longint'(table_q[i].deadline) - longint'(now)) - rem;
            if (lax >= 0) begin
                if (feas < 0 || table_q[i].deadline < table_q[feas].deadline ||
                    (table_q[i].deadline == table_q[feas].deadline &&
                     table_q[i].id < table_q[feas].id)) feas = i;
            end else if (infeas < 0 || table_q[i].id < table_q[infeas].id) begin
                infeas = i;
            end
        end
        if (missed >= 0) begin
            d = '{OUT_MISSED, 6'(missed), table_q[missed].id, 32'd0};
        end else if (feas >= 0) begin
            frem = longint'(table_q[feas].budget) - longint'(table_q[feas].done);
            alloc = longint'(table_q[feas].deadline) - longint'(now);
            if (frem < alloc) alloc = frem;
            for (int i = 0; i < NSlots; i++) begin
                if (!(table_q[i].rt && table_q[i].wait_f)) continue;
                if (longint'(table_q[i].start) >= longint'(now) + frem) continue;
                wake_end = longint'(table_q[i].start) + longint'(table_q[i].period);
                if (wake_end > longint'(table_q[feas].deadline)) continue;
                if (wake_end == longint'(table_q[feas].deadline) &&
                    table_q[i].id > table_q[feas].id) continue;
                wd = longint'(table_q[i].start) - longint'(now);
                if (alloc > wd) alloc = wd;
            end
            d = '{OUT_FEASIBLE, 6'(feas), table_q[feas].id, 32'(alloc)};
        end else if (infeas >= 0) begin
            d = '{OUT_INFEASIBLE, 6'(infeas), table_q[infeas].id, 32'd0};
        end
        return d;
    endfunction

    function automatic logic [30:0] near(input logic [30:0] base, input int span);
        return base + 31'($urandom_range(2 * span)) - 31'(span);
    endfunction

    // Random slot contents clustered around the request tick so that every
    // outcome and the wake-up clipping are reached often.
    function automatic t_item rand_write(input logic [30:0] now);
        t_item it;
        it = t_item'(ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom}));
        it.slot = 6'($urandom_range(NSlots - 1));
        if ($urandom_range(9) != 0) begin
            it.budget = 31'($urandom_range(60));
            it.done = 31'($urandom_range(60));
            it.deadline = near(now, 80);
            it.start = near(now, 60);
            it.period = 31'($urandom_range(120));
            it.id = 16'($urandom_range(($urandom_range(1)) ? 15 : 65535));
        end
        return it;
    endfunction

    task automatic send(input logic kind, input t_item it, input bit idle);
        if (idle && !quiet_tail && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= InDataW'({it.now, it.id, it.start, it.period, it.deadline,
                                   it.done, it.budget, it.wait_f, it.rt, it.run, it.slot});
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_WRITE) begin
            table_q[it.slot] = '{it.run, it.rt, it.wait_f, it.budget, it.done,
                                 it.deadline, it.period, it.start, it.id};
        end else begin
            decisions_due.push_back(decide(it.now));
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (decisions_due.size() != 0);
    endtask

    // Result checking at the accepting edge.
    always @(posedge i_clk) begin
        t_decision got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{t_outcome'(m_axis_tuser), m_axis_tdata[5:0], m_axis_tdata[21:6],
                    m_axis_tdata[53:22]};
            if (decisions_due.size() == 0) begin
                $error("unexpected transaction outcome=%0d", got.outcome);
                fail_count++;
            end else begin
                want = decisions_due.pop_front();
                if (got.outcome !== want.outcome) begin
                    $error("outcome expected %0d actual %0d", want.outcome, got.outcome);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("chosen_slot expected %0d actual %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.id !== want.id) begin
                    $error("chosen_id expected %0d actual %0d", want.id, got.id);
                    fail_count++;
                end
                if (got.alloc !== want.alloc) begin
                    $error("granted_ticks expected %0d actual %0d",
                           $signed(want.alloc), $signed(got.alloc));
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, none at the end.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_row wr(input t_item it);
        return '{KIND_WRITE, it, 1'b0, '0};
    endfunction

    function automatic t_row sc(input logic [30:0] now, input bit has, input t_decision d);
        t_item it;
        it = '1;
        it.now = now;
        return '{KIND_SCHED, it, has, d};
    endfunction

    initial begin
        t_item it;
        t_decision want;
        logic [30:0] now;
        for (int i = 0; i < NSlots; i++) table_q[i] = '0;

        // Empty table after reset gives no winner.
        rows.push_back(sc(31'h7fffffff, 1, '{OUT_NONE, 6'd0, 16'd0, 32'd0}));
        rows.push_back(sc(31'd0, 1, '{OUT_NONE, 6'd0, 16'd0, 32'd0}));
        // Missed deadline at the extremes; on equal ids the lower slot wins.
        rows.push_back(wr('{6'd63, 1, 1, 0, 31'h7fffffff, 31'd0, 31'd0, 31'd0, 31'd0,
                            16'hffff, 31'h7fffffff}));
        rows.push_back(sc(31'h7fffffff, 1, '{OUT_MISSED, 6'd63, 16'hffff, 32'd0}));
        rows.push_back(wr('{6'd0, 1, 1, 0, 31'd5, 31'd0, 31'd0, 31'd0, 31'd0,
                            16'hffff, 31'd0}));
        rows.push_back(sc(31'd10, 1, '{OUT_MISSED, 6'd0, 16'hffff, 32'd0}));
        // Clear them; infeasible task at the extremes.
        rows.push_back(wr('{6'd63, 0, 0, 0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 16'd0, 31'd0}));
        rows.push_back(wr('{6'd0, 1, 1, 0, 31'h7fffffff, 31'd0, 31'h7fffffff, 31'd0, 31'd0,
                            16'd0, 31'd0}));
        rows.push_back(sc(31'd1, 1, '{OUT_INFEASIBLE, 6'd0, 16'd0, 32'd0}));
        // Feasible with no work left: wide laxity and a negative starting allocation.
        rows.push_back(wr('{6'd0, 1, 1, 0, 31'd0, 31'h7fffffff, 31'h7fffffff, 31'd0, 31'd0,
                            16'd7, 31'd0}));
        rows.push_back(sc(31'd0, 0, '0));
        rows.push_back(wr('{6'd5, 0, 1, 1, 31'd0, 31'd0, 31'd0, 31'h7fffffff, 31'd0,
                            16'd3, 31'd0}));
        rows.push_back(sc(31'd100, 0, '0));
        rows.push_back(wr('{6'd6, 1, 1, 1, 31'd10, 31'd2, 31'd50, 31'd20, 31'd30,
                            16'd7, 31'd0}));
        rows.push_back(wr('{6'd7, 1, 1, 0, 31'd10, 31'd2, 31'd50, 31'd20, 31'd30,
                            16'd7, 31'd0}));
        rows.push_back(sc(31'd20, 0, '0));
        rows.push_back(sc(31'h7fffffff, 0, '0));
        // Garbage in ignored fields; non-rt and runnable-only tasks.
        rows.push_back(wr('{6'd9, 1, 0, 1, 31'd9, 31'd0, 31'd90, 31'd5, 31'd3,
                            16'd1, 31'h7fffffff}));
        rows.push_back(sc(31'd0, 0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == KIND_SCHED && rows[r].has_fixed) begin
                want = decide(rows[r].item.now);
                if (want !== rows[r].fixed) begin
                    $error("directed row %0d: outcome expected %0d actual %0d",
                           r, rows[r].fixed.outcome, want.outcome);
                    fail_count++;
                end
            end
            send(rows[r].kind, rows[r].item, 1);
        end

        for (int n = 0; n < NumRandom; n++) begin
            if (n == 100) hold_off = 1'b1;
            if (n == 250) drain();
            if (n == NumRandom - 100) quiet_tail = 1'b1;
            now = 31'($urandom_range(1) ? $urandom : $urandom_range(300, 100));
            if ($urandom_range(3) == 0) begin
                it = t_item'(ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom}));
                send(KIND_SCHED, it, 1);
            end else begin
                repeat ($urandom_range(4)) send(KIND_WRITE, rand_write(now), 1);
                it = t_item'(ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom}));
                it.now = now;
                send(KIND_SCHED, it, 1);
            end
        end

        drain();
        repeat (IdleTail) @(posedge i_clk);
        if (fail_count == 0 && decisions_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
